[rtl/rsts_pkg.sv]
// package for the reconfigurable slot time scheduler
// holds port widths and the controller state type; no dependencies
package rsts_pkg;

  localparam int FIELD_W  = 48;  // width of every time field on the ports
  localparam int CHOSEN_W = 3;   // width of the chosen slot field
  localparam int CFG_W    = 4;   // width of the slot count register

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BASE,
    ST_FIN,
    ST_UPDATE,
    ST_DONE
  } rsts_state_t;

endpackage

[rtl/reconfig_slot_time_scheduler.sv]
// top level of the reconfigurable slot time scheduler
// controller, slot memory sweeps and result strobe; uses rsts_pkg, rsts_slot_mem, rsts_load_port
//
// A request is taken when start is high and busy is low. The active slot
// count is slot_count, zero counting as one, capped at MAX_SLOTS. The result
// is shown on the result ports with done high for one cycle, and busy drops
// the cycle after. The slot memory has a single read port, which is swept
// twice: once to find the earliest free slot, and once to raise the slots
// below the new base time and write the finish time into the chosen slot.
// Results cannot be held off; the receiver must take done when it comes.
// slot_count may only be written while busy is low. After reset all slot
// times and the load port busy time are zero and slot_count is one; no
// clearing pass is needed.
module reconfig_slot_time_scheduler #(
  parameter int MAX_SLOTS = 8,
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rsts_pkg::FIELD_W-1:0]      current_time,
  input  logic [rsts_pkg::FIELD_W-1:0]      setup_time,
  input  logic [rsts_pkg::FIELD_W-1:0]      run_delay,
  input  logic                              cfg_wr_en,
  input  logic [rsts_pkg::CFG_W-1:0]        cfg_wr_data,
  output logic                              done,
  output logic [rsts_pkg::CHOSEN_W-1:0]     chosen_slot,
  output logic [rsts_pkg::FIELD_W-1:0]      slot_ready_time,
  output logic [rsts_pkg::FIELD_W-1:0]      slot_finish_time,
  output logic [rsts_pkg::FIELD_W-1:0]      load_start_time
);
  import rsts_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  rsts_state_t state, state_next;

  logic [CFG_W-1:0]     slot_count;
  logic [CNT_W-1:0]     n_lim;
  logic [CNT_W-1:0]     rd_cnt;
  logic [IDX_W-1:0]     chk_idx;
  logic                 chk_vld;
  logic                 chk_last;
  logic [IDX_W-1:0]     chosen;
  logic [TIME_BITS-1:0] now_q, setup_q, delay_q;
  logic [TIME_BITS-1:0] now_c, setup_c, delay_c;
  logic [TIME_BITS-1:0] min_q, base_q, finish_q;
  logic [TIME_BITS-1:0] load_start;
  logic [TIME_BITS:0]   base_sum, finish_sum;
  logic                 accept;
  logic                 rd_en, wr_en;
  logic [TIME_BITS-1:0] wr_data;
  logic [TIME_BITS-1:0] rd_data;
  logic [31:0]          cnt_ext;
  logic [31:0]          n_ext;

  assign accept = start && !busy;

  // input clamp to the time range
  generate
    if (TIME_BITS >= FIELD_W) begin : g_in_wide
      assign now_c   = TIME_BITS'(current_time);
      assign setup_c = TIME_BITS'(setup_time);
      assign delay_c = TIME_BITS'(run_delay);
    end else begin : g_in_narrow
      assign now_c   = (|current_time[FIELD_W-1:TIME_BITS]) ? '1 : current_time[TIME_BITS-1:0];
      assign setup_c = (|setup_time[FIELD_W-1:TIME_BITS]) ? '1 : setup_time[TIME_BITS-1:0];
      assign delay_c = (|run_delay[FIELD_W-1:TIME_BITS]) ? '1 : run_delay[TIME_BITS-1:0];
    end
  endgenerate

  // active slot count: zero means one, capped at the memory depth
  assign cnt_ext = 32'(slot_count);
  always_comb begin
    if (cnt_ext == 32'd0) begin
      n_ext = 32'd1;
    end else if (cnt_ext > 32'(MAX_SLOTS)) begin
      n_ext = 32'(MAX_SLOTS);
    end else begin
      n_ext = cnt_ext;
    end
  end
  assign n_lim = CNT_W'(n_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      slot_count <= cfg_wr_data;
    end
  end

  assign chk_last   = chk_vld && ({1'b0, chk_idx} == (IDX_W + 1)'(n_lim - CNT_W'(1)));
  assign base_sum   = {1'b0, min_q} + {1'b0, setup_q};
  assign finish_sum = {1'b0, base_q} + {1'b0, delay_q};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) begin
                   state_next = ST_SCAN;
                 end
      ST_SCAN:   if (chk_last) begin
                   state_next = ST_BASE;
                 end
      ST_BASE:   state_next = ST_FIN;
      ST_FIN:    state_next = ST_UPDATE;
      ST_UPDATE: if (chk_last) begin
                   state_next = ST_DONE;
                 end
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_data = base_q;
    done    = 1'b0;
    busy    = 1'b1;
    unique case (state)
      ST_IDLE:   busy = 1'b0;
      ST_SCAN:   rd_en = ({1'b0, rd_cnt} < {1'b0, n_lim});
      ST_BASE:   ;
      ST_FIN:    ;
      ST_UPDATE: begin
        rd_en = ({1'b0, rd_cnt} < {1'b0, n_lim});
        if (chk_vld) begin
          if (chk_idx == chosen) begin
            wr_en   = 1'b1;
            wr_data = finish_q;
          end else if (rd_data < base_q) begin
            wr_en = 1'b1;
          end
        end
      end
      ST_DONE:   done = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_cnt  <= '0;
      chk_vld <= 1'b0;
    end else begin
      state   <= state_next;
      chk_vld <= rd_en;
      if (accept || state == ST_BASE) begin
        rd_cnt <= '0;
      end else if (rd_en) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_idx <= rd_cnt[IDX_W-1:0];
    end
    if (accept) begin
      now_q   <= now_c;
      setup_q <= setup_c;
      delay_q <= delay_c;
    end
    // running minimum, lowest index kept on ties
    if (state == ST_SCAN && chk_vld) begin
      if (chk_idx == '0 || rd_data < min_q) begin
        min_q  <= rd_data;
        chosen <= chk_idx;
      end
    end
    if (state == ST_BASE) begin
      base_q <= base_sum[TIME_BITS] ? '1 : base_sum[TIME_BITS-1:0];
    end
    if (state == ST_FIN) begin
      finish_q <= finish_sum[TIME_BITS] ? '1 : finish_sum[TIME_BITS-1:0];
    end
  end

  rsts_slot_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (TIME_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (chk_idx),
    .wr_data (wr_data)
  );

  rsts_load_port #(
    .TIME_BITS (TIME_BITS)
  ) u_load (
    .clk        (clk),
    .rst        (rst),
    .capture    (accept),
    .now        (now_c),
    .setup      (setup_c),
    .load_start (load_start)
  );

  // result fields
  generate
    if (IDX_W >= CHOSEN_W) begin : g_idx_wide
      assign chosen_slot = chosen[CHOSEN_W-1:0];
    end else begin : g_idx_narrow
      assign chosen_slot = CHOSEN_W'(chosen);
    end
    if (TIME_BITS >= FIELD_W) begin : g_out_wide
      assign slot_ready_time  = min_q[FIELD_W-1:0];
      assign slot_finish_time = finish_q[FIELD_W-1:0];
      assign load_start_time  = load_start[FIELD_W-1:0];
    end else begin : g_out_narrow
      assign slot_ready_time  = FIELD_W'(min_q);
      assign slot_finish_time = FIELD_W'(finish_q);
      assign load_start_time  = FIELD_W'(load_start);
    end
  endgenerate

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_UPDATE))
    else $error("slot memory written outside the update sweep");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> ({1'b0, rd_cnt} < {1'b0, n_lim}))
    else $error("slot memory read beyond the active slot count");

endmodule

[rtl/rsts_slot_mem.sv]
// slot free-time memory: one write port, one registered read port
// entries never written read as zero through per-entry valid bits; uses rsts_pkg
module rsts_slot_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 48,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);
  import rsts_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] data_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

[rtl/rsts_load_port.sv]
// reconfiguration port busy time: load start and port reservation
// start is max(now, busy) taken on capture, busy is advanced the cycle after; uses rsts_pkg
module rsts_load_port #(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 capture,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] setup,
  output logic [TIME_BITS-1:0] load_start
);
  import rsts_pkg::*;

  logic [TIME_BITS-1:0] busy_q;
  logic [TIME_BITS-1:0] start_q;
  logic [TIME_BITS-1:0] setup_q;
  logic                 pend;
  logic [TIME_BITS:0]   sum;

  assign sum = {1'b0, start_q} + {1'b0, setup_q};

  always_ff @(posedge clk) begin
    if (capture) begin
      start_q <= (now > busy_q) ? now : busy_q;
      setup_q <= setup;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= '0;
      pend   <= 1'b0;
    end else begin
      pend <= capture;
      if (pend) begin
        // saturate on carry out
        busy_q <= sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
      end
    end
  end

  assign load_start = start_q;

endmodule
